@@ design/sst_pkg.sv @@
// Package for the sparse set component table.
// Holds the request and response structs, operation and status codes, sequencer states and sizes.
// No dependencies.
package sst_pkg;

  localparam int unsigned Capacity  = 256;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned MaxIdsDef = 1024;
  localparam int unsigned IdWidth   = 15;
  localparam int unsigned SlotW     = $clog2(Capacity);
  localparam int unsigned CountW    = SlotW + 1;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ABSENT  = 3'd1,
    ST_PRESENT = 3'd2,
    ST_FULL    = 3'd3,
    ST_RANGE   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SPARSE,
    S_DENSE,
    S_CHECK,
    S_MOVE,
    S_RESP
  } state_e;

  typedef struct packed {
    op_e                  op;
    logic [IdWidth-1:0]   entity_id;
    logic [DataWidth-1:0] component_in;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [SlotW-1:0]     slot;
    logic [DataWidth-1:0] component_out;
    logic [CountW-1:0]    member_count;
  } rsp_t;

endpackage

@@ design/sparse_set_component_table.sv @@
// Sparse set component table: maps an entity id to one packed component word.
// Depends on sst_pkg for the request/response structs, codes and sizes.
//
// One request is handled at a time; in_stall_o is high while a request is in flight
// and during the clearing pass. A search, insert or erase walks a chain of registered
// memory reads: the sparse slot of the id, then the dense id and component at that
// slot, and for an erase of a member the last member's id and component; a clear or
// an out-of-range id reads only the sparse slot. The result is written to the output
// register in the response step, after which the block returns to idle and can take
// the next request. The output register keeps the response while out_stall_i is high,
// and a request may be accepted meanwhile; only the final step waits for that register
// to free up. After reset a clearing pass over max(MAX_IDS, Capacity) addresses (1024
// with the defaults) zeroes the sparse and dense stores before the first request is
// accepted. Clear only resets the member count: stale entries fail the membership
// check, which requires the sparse slot to lie below the count and the dense store
// to hold the id there. Statuses: ok, not present, already present, set full, id out
// of range.
module sparse_set_component_table
  import sst_pkg::*;
#(
  parameter int unsigned MAX_IDS = MaxIdsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned IdxW = $clog2(MAX_IDS);
  localparam int unsigned ClrN = (MAX_IDS > Capacity) ? MAX_IDS : Capacity;
  localparam int unsigned ClrW = $clog2(ClrN);

  // stores
  logic [SlotW-1:0]     sparse_mem [MAX_IDS];
  logic [IdWidth-1:0]   dense_mem  [Capacity];
  logic [DataWidth-1:0] comp_mem   [Capacity];

  state_e state_q, state_d;
  logic [ClrW-1:0]      clr_q, clr_d;
  req_t                 req_q;
  logic [SlotW-1:0]     sparse_rd_q;
  logic [IdWidth-1:0]   dense_rd_q;
  logic [DataWidth-1:0] comp_rd_q;
  logic [CountW-1:0]    count_q, count_d;
  rsp_t                 res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  rsp_t                 out_rsp_q;

  // memory port controls
  logic                 sparse_rd_en;
  logic                 sparse_we;
  logic [IdxW-1:0]      sparse_waddr;
  logic [SlotW-1:0]     sparse_wdata;
  logic                 dense_rd_en;
  logic [SlotW-1:0]     dense_raddr;
  logic                 dense_we;
  logic [SlotW-1:0]     dense_waddr;
  logic [IdWidth-1:0]   dense_wdata;
  logic                 comp_we;
  logic [DataWidth-1:0] comp_wdata;

  logic accept;
  logic out_free;
  logic in_range;
  logic found;
  logic clr_last;
  logic [IdxW-1:0] id_idx;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_range = {1'b0, req_q.entity_id} < (IdWidth + 1)'(MAX_IDS);
  assign found    = ({1'b0, sparse_rd_q} < count_q) && (dense_rd_q == req_q.entity_id);
  assign clr_last = (clr_q == ClrW'(ClrN - 1));
  assign id_idx   = req_q.entity_id[IdxW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (clr_last) state_d = S_IDLE;
      S_IDLE:   if (accept) state_d = S_SPARSE;
      S_SPARSE: begin
        if (req_q.op == OP_CLEAR || !in_range) state_d = S_RESP;
        else state_d = S_DENSE;
      end
      S_DENSE:  state_d = S_CHECK;
      S_CHECK:  begin
        if (req_q.op == OP_ERASE && found) state_d = S_MOVE;
        else state_d = S_RESP;
      end
      S_MOVE:   state_d = S_RESP;
      S_RESP:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_CLEAR;
    endcase
  end

  // sequencer outputs: memory ports, count and response
  always_comb begin
    clr_d        = clr_q;
    count_d      = count_q;
    res_d        = res_q;
    sparse_rd_en = 1'b0;
    sparse_we    = 1'b0;
    sparse_waddr = id_idx;
    sparse_wdata = count_q[SlotW-1:0];
    dense_rd_en  = 1'b0;
    dense_raddr  = sparse_rd_q;
    dense_we     = 1'b0;
    dense_waddr  = count_q[SlotW-1:0];
    dense_wdata  = req_q.entity_id;
    comp_we      = 1'b0;
    comp_wdata   = req_q.component_in;
    out_valid_d  = out_valid_q && out_stall_i;

    unique case (state_q)
      S_CLEAR: begin
        clr_d        = clr_q + 1'b1;
        sparse_we    = {1'b0, clr_q} < (ClrW + 1)'(MAX_IDS);
        sparse_waddr = clr_q[IdxW-1:0];
        sparse_wdata = '0;
        dense_we     = {1'b0, clr_q} < (ClrW + 1)'(Capacity);
        dense_waddr  = clr_q[SlotW-1:0];
        dense_wdata  = '0;
      end
      S_IDLE: ;
      S_SPARSE: begin
        sparse_rd_en        = 1'b1;
        res_d.status        = ST_OK;
        res_d.slot          = '0;
        res_d.component_out = '0;
        if (req_q.op == OP_CLEAR) begin
          count_d = '0;
        end else if (!in_range) begin
          res_d.status = ST_RANGE;
        end
      end
      S_DENSE: begin
        dense_rd_en = 1'b1;
      end
      S_CHECK: begin
        unique case (req_q.op)
          OP_SEARCH: begin
            if (found) begin
              res_d.slot          = sparse_rd_q;
              res_d.component_out = comp_rd_q;
            end else begin
              res_d.status = ST_ABSENT;
            end
          end
          OP_INSERT: begin
            if (found) begin
              res_d.status = ST_PRESENT;
            end else if (count_q == CountW'(Capacity)) begin
              res_d.status = ST_FULL;
            end else begin
              sparse_we  = 1'b1;
              dense_we   = 1'b1;
              comp_we    = 1'b1;
              count_d    = count_q + 1'b1;
              res_d.slot = count_q[SlotW-1:0];
            end
          end
          OP_ERASE: begin
            if (found) begin
              // fetch the last member to fill the hole
              dense_rd_en = 1'b1;
              dense_raddr = SlotW'(count_q - 1'b1);
            end else begin
              res_d.status = ST_ABSENT;
            end
          end
          OP_CLEAR: ;
          default: ;
        endcase
      end
      S_MOVE: begin
        sparse_we    = 1'b1;
        sparse_waddr = dense_rd_q[IdxW-1:0];
        sparse_wdata = sparse_rd_q;
        dense_we     = 1'b1;
        dense_waddr  = sparse_rd_q;
        dense_wdata  = dense_rd_q;
        comp_we      = 1'b1;
        comp_wdata   = comp_rd_q;
        count_d      = count_q - 1'b1;
        res_d.slot   = sparse_rd_q;
      end
      S_RESP: begin
        res_d.member_count = count_q;
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (sparse_we) sparse_mem[sparse_waddr] <= sparse_wdata;
    if (sparse_rd_en) sparse_rd_q <= sparse_mem[id_idx];
  end

  always_ff @(posedge clk_i) begin
    if (dense_we) dense_mem[dense_waddr] <= dense_wdata;
    if (dense_rd_en) dense_rd_q <= dense_mem[dense_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (comp_we) comp_mem[dense_waddr] <= comp_wdata;
    if (dense_rd_en) comp_rd_q <= comp_mem[dense_raddr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_req_i;
    res_q <= res_d;
    // res_d carries the final member count in the response step
    if (state_q == S_RESP && out_free) out_rsp_q <= res_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

@@ tb/sparse_set_component_table_tb.sv @@
// Self-checking testbench for the sparse set component table.
// Drives search, insert, erase and clear requests and checks every response against its own
// model of the set or a typed expected response. Depends on sst_pkg and sparse_set_component_table.
`timescale 1ns / 100ps

module sparse_set_component_table_tb;
  import sst_pkg::*;

  localparam int unsigned IdLimit     = MaxIdsDef;
  localparam int unsigned StallLimit  = 20000;  // cycles with no handshake on either side
  localparam int unsigned DrainCycles = 12;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  // Model of the set contents
  logic [SlotW-1:0]     sparse_slot_m [IdLimit];
  logic [IdWidth-1:0]   dense_id_m    [Capacity];
  logic [DataWidth-1:0] packed_word_m [Capacity];
  int unsigned          members_m;

  rsp_t        pending_rsp_q [$];
  dir_row_t    directed_rows [$];
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned reqs_sent = 0;
  int unsigned rsps_checked = 0;
  int unsigned quiet_cycles = 0;

  sparse_set_component_table #(
    .MAX_IDS(IdLimit)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one request to the model and returns the response it should give.
  function automatic rsp_t table_predict(req_t r);
    rsp_t                rsp;
    logic [SlotW-1:0]    pos;
    logic [IdWidth-1:0]  moved;
    int unsigned         last;
    bit                  hit;
    rsp = '0;
    rsp.status = ST_OK;
    if (r.op == OP_CLEAR) begin
      members_m = 0;   // stale entries stay, membership check rejects them
    end else if (r.entity_id >= IdLimit) begin
      rsp.status = ST_RANGE;
    end else begin
      pos = sparse_slot_m[r.entity_id];
      hit = (pos < members_m) && (dense_id_m[pos] == r.entity_id);
      case (r.op)
        OP_SEARCH: begin
          if (hit) begin
            rsp.slot = pos;
            rsp.component_out = packed_word_m[pos];
          end else begin
            rsp.status = ST_ABSENT;
          end
        end
        OP_INSERT: begin
          if (hit) begin
            rsp.status = ST_PRESENT;
          end else if (members_m >= Capacity) begin
            rsp.status = ST_FULL;
          end else begin
            pos = SlotW'(members_m);
            dense_id_m[pos] = r.entity_id;
            sparse_slot_m[r.entity_id] = pos;
            packed_word_m[pos] = r.component_in;
            members_m = members_m + 1;
            rsp.slot = pos;
          end
        end
        default: begin
          if (hit) begin
            // last member fills the hole
            last = members_m - 1;
            moved = dense_id_m[last];
            dense_id_m[pos] = moved;
            if (moved < IdLimit) sparse_slot_m[moved] = pos;
            packed_word_m[pos] = packed_word_m[last];
            members_m = last;
            rsp.slot = pos;
          end else begin
            rsp.status = ST_ABSENT;
          end
        end
      endcase
    end
    rsp.member_count = CountW'(members_m);
    return rsp;
  endfunction

  // Mostly in-range requests on a pool of ids, plus a little out-of-range noise.
  function automatic req_t random_req(int unsigned id_span, int unsigned insert_pct);
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(99);
    r.component_in = $urandom;
    r.entity_id = IdWidth'($urandom_range(id_span - 1));
    if (pick < insert_pct) begin
      r.op = OP_INSERT;
    end else if (pick < insert_pct + (92 - insert_pct) / 2) begin
      r.op = OP_SEARCH;
    end else if (pick < 92) begin
      r.op = OP_ERASE;
    end else if (pick < 94) begin
      r.op = OP_CLEAR;
      r.entity_id = IdWidth'($urandom);
    end else begin
      r.op = op_e'($urandom_range(3));
      r.entity_id = IdWidth'($urandom_range(32767, IdLimit));
    end
    return r;
  endfunction

  task automatic add_row(input op_e op, input int unsigned id, input logic [31:0] data,
                         input bit typed, input status_e st, input int unsigned slot,
                         input logic [31:0] comp, input int unsigned cnt);
    dir_row_t row;
    row.req.op = op;
    row.req.entity_id = IdWidth'(id);
    row.req.component_in = data;
    row.typed = typed;
    row.rsp.status = st;
    row.rsp.slot = SlotW'(slot);
    row.rsp.component_out = comp;
    row.rsp.member_count = CountW'(cnt);
    directed_rows.push_back(row);
  endtask

  // Called at a clock edge; returns at the edge the request is taken.
  task automatic issue_req(input req_t r, input bit typed, input rsp_t typed_rsp);
    rsp_t model_rsp;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    model_rsp = table_predict(r);
    pending_rsp_q.push_back(typed ? typed_rsp : model_rsp);
    reqs_sent++;
  endtask

  task automatic wait_drained;
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int unsigned n, input int unsigned id_span,
                              input int unsigned insert_pct);
    for (int unsigned i = 0; i < n; i++) issue_req(random_req(id_span, insert_pct), 1'b0, '0);
  endtask

  // Receiver back-pressure
  always @(posedge clk) out_stall_i <= ($urandom_range(99) < rx_idle_pct);

  // Response checker
  always @(posedge clk) begin : check_rsp
    rsp_t exp_rsp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rsps_checked++;
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: response with none expected, status %0d slot %0d", $time,
                 out_rsp_o.status, out_rsp_o.slot);
        mismatches++;
      end else begin
        exp_rsp = pending_rsp_q.pop_front();
        if (out_rsp_o.status !== exp_rsp.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status,
                   out_rsp_o.status);
          mismatches++;
        end
        if (out_rsp_o.slot !== exp_rsp.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, exp_rsp.slot, out_rsp_o.slot);
          mismatches++;
        end
        if (out_rsp_o.component_out !== exp_rsp.component_out) begin
          $display("%0t: component expected %h actual %h", $time, exp_rsp.component_out,
                   out_rsp_o.component_out);
          mismatches++;
        end
        if (out_rsp_o.member_count !== exp_rsp.member_count) begin
          $display("%0t: count expected %0d actual %0d", $time, exp_rsp.member_count,
                   out_rsp_o.member_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: covers the clearing pass after reset and long stall runs
  always @(posedge clk) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    for (int unsigned i = 0; i < IdLimit; i++) sparse_slot_m[i] = '0;
    for (int unsigned i = 0; i < Capacity; i++) begin
      dense_id_m[i] = '0;
      packed_word_m[i] = '0;
    end
    members_m = 0;

    // Directed table: typed rows are plain to read off, the rest go through the model
    add_row(OP_SEARCH, 0,     32'h0,        1'b1, ST_ABSENT,  0, 32'h0,        0);
    add_row(OP_INSERT, 0,     32'h0,        1'b1, ST_OK,      0, 32'h0,        1);
    add_row(OP_INSERT, 1023,  32'hFFFFFFFF, 1'b1, ST_OK,      1, 32'h0,        2);
    add_row(OP_SEARCH, 1023,  32'h0,        1'b1, ST_OK,      1, 32'hFFFFFFFF, 2);
    add_row(OP_SEARCH, 0,     32'hFFFFFFFF, 1'b1, ST_OK,      0, 32'h0,        2);
    add_row(OP_INSERT, 0,     32'h12345678, 1'b1, ST_PRESENT, 0, 32'h0,        2);
    add_row(OP_SEARCH, 1024,  32'h0,        1'b1, ST_RANGE,   0, 32'h0,        2);
    add_row(OP_INSERT, 32767, 32'hFFFFFFFF, 1'b1, ST_RANGE,   0, 32'h0,        2);
    add_row(OP_ERASE,  32767, 32'h0,        1'b1, ST_RANGE,   0, 32'h0,        2);
    add_row(OP_ERASE,  5,     32'h0,        1'b1, ST_ABSENT,  0, 32'h0,        2);
    add_row(OP_INSERT, 5,     32'hA5A5A5A5, 1'b0, ST_OK,      0, 32'h0,        0);
    add_row(OP_ERASE,  0,     32'h0,        1'b0, ST_OK,      0, 32'h0,        0);
    add_row(OP_SEARCH, 5,     32'h0,        1'b0, ST_OK,      0, 32'h0,        0);
    add_row(OP_SEARCH, 0,     32'h0,        1'b0, ST_OK,      0, 32'h0,        0);
    add_row(OP_ERASE,  5,     32'h0,        1'b0, ST_OK,      0, 32'h0,        0);
    add_row(OP_SEARCH, 1023,  32'h0,        1'b0, ST_OK,      0, 32'h0,        0);
    add_row(OP_CLEAR,  32767, 32'hFFFFFFFF, 1'b1, ST_OK,      0, 32'h0,        0);
    add_row(OP_SEARCH, 1023,  32'h0,        1'b1, ST_ABSENT,  0, 32'h0,        0);
    add_row(OP_ERASE,  1023,  32'h0,        1'b1, ST_ABSENT,  0, 32'h0,        0);
    add_row(OP_INSERT, 1023,  32'h5A5A5A5A, 1'b1, ST_OK,      0, 32'h0,        1);
    add_row(OP_SEARCH, 1023,  32'h0,        1'b0, ST_OK,      0, 32'h0,        0);

    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;

    tx_idle_pct = 25;
    rx_idle_pct = 73;
    foreach (directed_rows[i]) issue_req(directed_rows[i].req, directed_rows[i].typed,
                                         directed_rows[i].rsp);
    wait_drained();   // sender holds off until every response is back

    // Fill to capacity, then poke the full set
    for (int unsigned k = 0; k < Capacity - 1; k++)
      issue_req('{op: OP_INSERT, entity_id: IdWidth'(4 * k), component_in: $urandom}, 1'b0, '0);
    issue_req('{op: OP_INSERT, entity_id: 15'd2,    component_in: $urandom}, 1'b0, '0);
    issue_req('{op: OP_INSERT, entity_id: 15'd1023, component_in: $urandom}, 1'b0, '0);
    issue_req('{op: OP_SEARCH, entity_id: 15'd1016, component_in: 32'h0}, 1'b0, '0);
    issue_req('{op: OP_ERASE,  entity_id: 15'd0,    component_in: 32'h0}, 1'b0, '0);
    issue_req('{op: OP_INSERT, entity_id: 15'd2,    component_in: $urandom}, 1'b0, '0);
    issue_req('{op: OP_INSERT, entity_id: 15'd3,    component_in: $urandom}, 1'b0, '0);
    issue_req('{op: OP_SEARCH, entity_id: 15'd2,    component_in: 32'h0}, 1'b0, '0);
    issue_req('{op: OP_SEARCH, entity_id: 15'd1016, component_in: 32'h0}, 1'b0, '0);
    issue_req('{op: OP_CLEAR,  entity_id: 15'd0,    component_in: 32'h0}, 1'b0, '0);

    // Random part: small pool for frequent hits, a wider insert-heavy pool, then another small pool
    random_phase(40, 48, 36);
    wait_drained();
    tx_idle_pct = 73;
    rx_idle_pct = 25;
    random_phase(40, 320, 50);
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(40, 64, 36);

    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("%0d requests issued and %0d responses checked: search, insert, erase, clear,",
             reqs_sent, rsps_checked);
    $display("out-of-range ids and a full set, under three sender/receiver stall mixes");
    if (mismatches == 0 && pending_rsp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/sst_pkg.sv
design/sparse_set_component_table.sv
tb/sparse_set_component_table_tb.sv
